### sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int POS_W       = 11;
	localparam int IDX_W       = 11;
	localparam int ACTION_W    = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;
	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'd7;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
	localparam logic [CHAR_W-1:0] CH_DEL      = 8'd127;
	localparam int                TAB_STEP    = 8;

	// configuration register indexes
	localparam logic [0:0] REG_ATTRIBUTE   = 1'b0;
	localparam logic [0:0] REG_INTERACTIVE = 1'b1;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_CLEAR,
		ST_FINISH
	} state_t;

endpackage

### sv/tcw_screen_mem.sv
// Screen cell store: one write port, one registered read port.
module tcw_screen_mem #(
	parameter int DEPTH = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
	logic [tcw_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/tcw_put_unit.sv
// Character interpreter: next cursor, cell write and scroll request for a put.
module tcw_put_unit #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS,
	parameter int CW      = $clog2(COLUMNS),
	parameter int RW      = $clog2(ROWS),
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  logic [CW-1:0]               col,
	input  logic [RW-1:0]               row,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ATTR_W-1:0]  attribute,
	input  logic                        interactive_mode,
	output logic [CW-1:0]               next_col,
	output logic [RW-1:0]               next_row,
	output logic                        scroll,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output logic [tcw_pkg::CELL_W-1:0]  wdata
);

	localparam int XW = CW + 4;
	localparam logic [XW-1:0] TAB_MASK = ~XW'(tcw_pkg::TAB_STEP - 1);

	logic [XW-1:0]   ncol;
	logic [RW:0]     nrow;
	logic            erase;
	logic            printable;
	logic [AW-1:0]   base;

	assign printable = (char_code >= tcw_pkg::CH_SPACE) && !char_code[tcw_pkg::CHAR_W-1];
	assign base      = AW'(row) * AW'(COLUMNS);

	always_comb begin
		ncol   = XW'(col);
		nrow   = (RW+1)'(row);
		we     = 1'b0;
		erase  = 1'b0;
		scroll = 1'b0;
		if (char_code == tcw_pkg::CH_TAB) begin
			ncol = (ncol + XW'(tcw_pkg::TAB_STEP)) & TAB_MASK;
		end else if (interactive_mode) begin
			if (char_code == tcw_pkg::CH_BS || char_code == tcw_pkg::CH_DEL) begin
				if (col != '0) begin
					ncol  = ncol - XW'(1);
					we    = 1'b1;
					erase = 1'b1;
				end
			end else if (char_code == tcw_pkg::CH_LF || char_code == tcw_pkg::CH_CR) begin
				ncol = '0;
				nrow = nrow + (RW+1)'(1);
			end else if (printable) begin
				we   = 1'b1;
				ncol = ncol + XW'(1);
			end
		end else begin
			if (char_code == tcw_pkg::CH_BS) begin
				if (col != '0) begin
					ncol = ncol - XW'(1);
				end
			end else if (char_code == tcw_pkg::CH_CR) begin
				ncol = '0;
			end else if (char_code == tcw_pkg::CH_LF) begin
				ncol = '0;
				nrow = nrow + (RW+1)'(1);
			end else if (printable) begin
				we   = 1'b1;
				ncol = ncol + XW'(1);
			end
		end
		// wrap past last column, then scroll past last row
		if (ncol >= XW'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + (RW+1)'(1);
		end
		if (nrow >= (RW+1)'(ROWS)) begin
			scroll = 1'b1;
			nrow   = (RW+1)'(ROWS - 1);
		end
	end

	assign next_col = ncol[CW-1:0];
	assign next_row = nrow[RW-1:0];
	assign waddr    = base + AW'(col) - AW'(erase);
	assign wdata    = erase ? {attribute, tcw_pkg::CH_SPACE} : {attribute, char_code};

endmodule

### sv/text_console_writer.sv
// Text console writer: cell store, cursor, control sequencer and stream ports.
// Sequence: a read and a put without scroll go from ST_IDLE to ST_FINISH, which loads the result
// word once the output register is free; clear and a put that scrolls first sweep every cell (one cell per cycle).
// Input words are taken one at a time, only in ST_IDLE; a word is taken while
// the previous result still waits on the output register.
// Reset: asynchronous; then a clearing pass over every cell fills the store
// with 0x0720 while s_tready stays low (configuration writes are taken).
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave word, low bit up: action[1:0], char_code[9:2], cell_index[20:10], zero pad
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tcw_pkg::IN_TDATA_W-1:0]    s_tdata,
	// master word, low bit up: cursor_pos[10:0], cell_data[26:11], zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tcw_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = $clog2(CELLS);
	// linear width: holds CELLS itself and the 11-bit cursor field
	localparam int LW    = (AW + 1 > tcw_pkg::POS_W) ? AW + 1 : tcw_pkg::POS_W;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);

	// input word fields
	tcw_pkg::action_t              in_action;
	logic [tcw_pkg::CHAR_W-1:0]    in_char;
	logic [tcw_pkg::IDX_W-1:0]     in_idx;
	logic [LW-1:0]                 in_idx_lw;
	logic                          in_hit;
	logic                          acc_in;

	assign in_action = tcw_pkg::action_t'(s_tdata[1:0]);
	assign in_char   = s_tdata[9:2];
	assign in_idx    = s_tdata[20:10];
	assign in_idx_lw = LW'(in_idx);
	assign in_hit    = in_idx_lw < LW'(CELLS);

	// control and architectural state
	tcw_pkg::state_t              state_q, state_d;
	logic [AW-1:0]                sweep_q;
	logic                         sweep_last;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [tcw_pkg::ATTR_W-1:0]   attr_q;
	logic                         imode_q;
	logic                         rd_hit_q;
	logic [tcw_pkg::CELL_W-1:0]   blank;

	assign sweep_last = sweep_q == LAST_CELL;
	assign blank      = {attr_q, tcw_pkg::CH_SPACE};

	// scroll copy pipeline: each write follows its read in the next cycle
	logic                         wr_s1;
	logic [AW-1:0]                waddr_s1;
	logic                         blank_s1;

	// put interpreter
	logic [CW-1:0]                put_col;
	logic [RW-1:0]                put_row;
	logic                         put_scroll;
	logic                         put_we;
	logic [AW-1:0]                put_waddr;
	logic [tcw_pkg::CELL_W-1:0]   put_wdata;

	tcw_put_unit #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CW      (CW),
		.RW      (RW),
		.AW      (AW)
	) u_put (
		.col              (col_q),
		.row              (row_q),
		.char_code        (in_char),
		.attribute        (attr_q),
		.interactive_mode (imode_q),
		.next_col         (put_col),
		.next_row         (put_row),
		.scroll           (put_scroll),
		.we               (put_we),
		.waddr            (put_waddr),
		.wdata            (put_wdata)
	);

	// memory port
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

	tcw_screen_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	logic                              m_tvalid_q;
	logic [tcw_pkg::POS_W-1:0]         out_pos_q;
	logic [tcw_pkg::CELL_W-1:0]        out_data_q;
	logic                              load_out;
	logic [LW-1:0]                     pos_lin;

	assign load_out = (state_q == tcw_pkg::ST_FINISH) && (!m_tvalid_q || m_tready);
	assign pos_lin  = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
	assign acc_in   = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (sweep_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (acc_in) begin
					case (in_action)
						tcw_pkg::ACT_PUT:   state_d = put_scroll ? tcw_pkg::ST_SCROLL
						                                         : tcw_pkg::ST_FINISH;
						tcw_pkg::ACT_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						default:            state_d = tcw_pkg::ST_FINISH;
					endcase
				end
			end
			tcw_pkg::ST_SCROLL, tcw_pkg::ST_CLEAR: begin
				if (sweep_last) state_d = tcw_pkg::ST_FINISH;
			end
			tcw_pkg::ST_FINISH: begin
				if (load_out) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// sequencer outputs: handshake and memory port
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = sweep_q + AW'(COLUMNS);
		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = tcw_pkg::RESET_BLANK;
			end
			tcw_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				mem_we    = acc_in && (in_action == tcw_pkg::ACT_PUT) && put_we;
				mem_waddr = put_waddr;
				mem_wdata = put_wdata;
				mem_re    = acc_in && (in_action == tcw_pkg::ACT_READ) && in_hit;
				mem_raddr = in_idx_lw[AW-1:0];
			end
			tcw_pkg::ST_SCROLL: begin
				mem_re = sweep_q < LAST_BASE;
			end
			tcw_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
		// delayed scroll write; never overlaps the direct writes above
		if (wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = blank_s1 ? blank : mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
			sweep_q <= '0;
			wr_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_s1   <= state_q == tcw_pkg::ST_SCROLL;
			if (state_q == tcw_pkg::ST_INIT || state_q == tcw_pkg::ST_SCROLL ||
			    state_q == tcw_pkg::ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= sweep_q;
		blank_s1 <= sweep_q >= LAST_BASE;
	end

	// cursor, read flag and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rd_hit_q <= 1'b0;
			attr_q   <= tcw_pkg::RESET_ATTR;
			imode_q  <= 1'b0;
		end else begin
			if (acc_in) begin
				rd_hit_q <= (in_action == tcw_pkg::ACT_READ) && in_hit;
				case (in_action)
					tcw_pkg::ACT_PUT: begin
						col_q <= put_col;
						row_q <= put_row;
					end
					tcw_pkg::ACT_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::REG_ATTRIBUTE:   attr_q  <= cfg_wdata;
					tcw_pkg::REG_INTERACTIVE: imode_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pos_q  <= pos_lin[tcw_pkg::POS_W-1:0];
			out_data_q <= rd_hit_q ? mem_rdata : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(tcw_pkg::OUT_TDATA_W - tcw_pkg::POS_W - tcw_pkg::CELL_W)'(0),
	                   out_data_q, out_pos_q};

endmodule

### sv/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [tcw_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int CELLS = COLUMNS * ROWS;

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result word changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// cursor stays inside the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((CELLS > 2048) || (m_tdata[10:0] < 11'(CELLS))))
		else $error("cursor position outside the screen");

	// accepted items do not overlap: no accept right after an accept
	a_result_between: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##1 !(s_tvalid && s_tready))
		else $error("items overlap");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
